// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Holds field widths, character codes, the command format between the
// front and back parts, and the back-end state encoding. No dependencies.
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths fixed by the stream format
  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int CCOL_W  = 7;
  localparam int CROW_W  = 5;
  localparam int CELL_W  = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Function codes on tuser
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Character and attribute codes
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;
  localparam logic [CHAR_W-1:0] SPACE_CHAR     = 8'h20;
  localparam logic [ATTR_W-1:0] BLANK_ATTR     = 8'h0F;

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_CLEAR,
    CMD_READ,
    CMD_READ_NONE,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAR_W-1:0]  ch;
    logic [ATTR_W-1:0]  attr;
    logic [RROW_W-1:0]  rd_row;
    logic [RCOL_W-1:0]  rd_col;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_READ,
    ST_DONE
  } back_state_t;

endpackage

// ===== rtl/tcw_front.sv =====
// Front end of the text console writer: accepts input transactions,
// classifies them into commands and queues them for the back end.
// Depends on tcw_pkg.
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept_en,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] char_code, [15:8] color, [20:16] read_row, [27:21] read_col
  input  logic [tcw_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [1:0] func
  input  logic [tcw_pkg::FUNC_W-1:0]         s_tuser,
  input  logic                               pop,
  output tcw_pkg::queue_head_t               head
);

  localparam int PTR_W = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tcw_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(tcw_pkg::QUEUE_DEPTH);

  tcw_pkg::cmd_t             q [tcw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]          wr_ptr;
  logic [PTR_W-1:0]          rd_ptr;
  logic [CNT_W-1:0]          count;
  tcw_pkg::cmd_t             cmd_in;
  logic                      push;
  logic                      do_pop;
  logic [tcw_pkg::CHAR_W-1:0] ch;
  logic [tcw_pkg::ATTR_W-1:0] attr;
  logic [tcw_pkg::RROW_W-1:0] rd_row;
  logic [tcw_pkg::RCOL_W-1:0] rd_col;
  logic                      read_in_range;

  // Unpack the payload
  assign ch     = s_tdata[7:0];
  assign attr   = s_tdata[15:8];
  assign rd_row = s_tdata[20:16];
  assign rd_col = s_tdata[27:21];

  assign read_in_range = (int'(rd_row) < ROWS) && (int'(rd_col) < COLUMNS);

  // Classify the transaction
  always_comb begin
    cmd_in.ch     = ch;
    cmd_in.attr   = attr;
    cmd_in.rd_row = rd_row;
    cmd_in.rd_col = rd_col;
    unique case (s_tuser)
      tcw_pkg::FUNC_PUT: begin
        if (ch == tcw_pkg::NEWLINE_CHAR) begin
          cmd_in.kind = tcw_pkg::CMD_NEWLINE;
        end else if (ch == tcw_pkg::BACKSPACE_CHAR) begin
          cmd_in.kind = tcw_pkg::CMD_BACKSPACE;
        end else begin
          cmd_in.kind = tcw_pkg::CMD_PUT;
        end
      end
      tcw_pkg::FUNC_CLEAR: cmd_in.kind = tcw_pkg::CMD_CLEAR;
      tcw_pkg::FUNC_READ: begin
        cmd_in.kind = read_in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_READ_NONE;
      end
      default: cmd_in.kind = tcw_pkg::CMD_NOP;
    endcase
  end

  // Queue control
  assign s_tready = accept_en && (count != FULL_CNT);
  assign push     = s_tvalid && s_tready;
  assign do_pop   = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.cmd   = q[rd_ptr];

  // Store queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// ===== rtl/tcw_back.sv =====
// Back end of the text console writer: owns the screen memory and the
// cursor, executes queued commands and holds the result register.
// Depends on tcw_pkg.
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tcw_pkg::queue_head_t               head,
  output logic                               pop,
  output logic                               accept_en,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PAD_W  = tcw_pkg::OUT_TDATA_W - tcw_pkg::CELL_W - 1
                          - tcw_pkg::CROW_W - tcw_pkg::CCOL_W;
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_MOVE = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  tcw_pkg::back_state_t        state, state_next;
  logic [COL_W-1:0]            col, col_next;
  logic [ROW_W-1:0]            row, row_next;
  logic [ADDR_W-1:0]           idx, idx_next;
  logic [tcw_pkg::ATTR_W-1:0]  fill_attr, fill_attr_next;
  logic                        res_scr, res_scr_next;
  logic [tcw_pkg::CELL_W-1:0]  res_cell, res_cell_next;
  logic                        out_load;
  logic                        advance;

  logic [tcw_pkg::CELL_W-1:0]  mem [CELLS];
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]  rdata;
  logic [ADDR_W-1:0]           cur_addr;
  logic [ADDR_W-1:0]           read_addr;

  // Cell addresses of the cursor and of a read command
  assign cur_addr  = ADDR_W'(row) * ROW_STEP + ADDR_W'(col);
  assign read_addr = ADDR_W'(head.cmd.rd_row) * ROW_STEP + ADDR_W'(head.cmd.rd_col);

  assign accept_en = (state != tcw_pkg::ST_INIT);

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Next state and datapath control
  always_comb begin
    state_next     = state;
    col_next       = col;
    row_next       = row;
    idx_next       = idx;
    fill_attr_next = fill_attr;
    res_scr_next   = res_scr;
    res_cell_next  = res_cell;
    mem_we         = 1'b0;
    mem_waddr      = idx;
    mem_wdata      = {tcw_pkg::BLANK_ATTR, tcw_pkg::SPACE_CHAR};
    mem_raddr      = ADDR_W'(idx + ROW_STEP);
    pop            = 1'b0;
    out_load       = 1'b0;
    advance        = 1'b0;
    unique case (state)
      // Blank the screen after reset
      tcw_pkg::ST_INIT: begin
        mem_we = 1'b1;
        if (idx == LAST_CELL) begin
          idx_next   = '0;
          state_next = tcw_pkg::ST_IDLE;
        end else begin
          idx_next = ADDR_W'(idx + 1'b1);
        end
      end
      // Take the next command
      tcw_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop           = 1'b1;
          res_scr_next  = 1'b0;
          res_cell_next = '0;
          state_next    = tcw_pkg::ST_DONE;
          unique case (head.cmd.kind)
            tcw_pkg::CMD_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {head.cmd.attr, head.cmd.ch};
              if (col == LAST_COL) begin
                col_next = '0;
                advance  = 1'b1;
              end else begin
                col_next = COL_W'(col + 1'b1);
              end
            end
            tcw_pkg::CMD_NEWLINE: begin
              col_next = '0;
              advance  = 1'b1;
            end
            tcw_pkg::CMD_BACKSPACE: begin
              if (col != '0) begin
                col_next  = COL_W'(col - 1'b1);
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(cur_addr - 1'b1);
                mem_wdata = {head.cmd.attr, tcw_pkg::SPACE_CHAR};
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              col_next   = '0;
              row_next   = '0;
              idx_next   = '0;
              state_next = tcw_pkg::ST_CLEAR;
            end
            tcw_pkg::CMD_READ: begin
              mem_raddr  = read_addr;
              state_next = tcw_pkg::ST_READ;
            end
            tcw_pkg::CMD_READ_NONE, tcw_pkg::CMD_NOP: begin
              state_next = tcw_pkg::ST_DONE;
            end
          endcase
          // Move to the next row, scrolling off the bottom
          if (advance) begin
            if (row == LAST_ROW) begin
              res_scr_next   = 1'b1;
              idx_next       = '0;
              fill_attr_next = head.cmd.attr;
              state_next     = tcw_pkg::ST_SCR_RD;
            end else begin
              row_next = ROW_W'(row + 1'b1);
            end
          end
        end
      end
      // Blank every cell
      tcw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (idx == LAST_CELL) begin
          state_next = tcw_pkg::ST_DONE;
        end else begin
          idx_next = ADDR_W'(idx + 1'b1);
        end
      end
      // Fetch the cell one row below
      tcw_pkg::ST_SCR_RD: begin
        state_next = tcw_pkg::ST_SCR_WR;
      end
      // Move it up one row
      tcw_pkg::ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata;
        idx_next  = ADDR_W'(idx + 1'b1);
        state_next = (idx == LAST_MOVE) ? tcw_pkg::ST_FILL : tcw_pkg::ST_SCR_RD;
      end
      // Fill the new bottom row with blanks
      tcw_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {fill_attr, tcw_pkg::SPACE_CHAR};
        if (idx == LAST_CELL) begin
          state_next = tcw_pkg::ST_DONE;
        end else begin
          idx_next = ADDR_W'(idx + 1'b1);
        end
      end
      // Capture the cell that was read
      tcw_pkg::ST_READ: begin
        res_cell_next = rdata;
        state_next    = tcw_pkg::ST_DONE;
      end
      // Hand the result to the output register
      tcw_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Sequencer and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
      col   <= '0;
      row   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      idx   <= idx_next;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    fill_attr <= fill_attr_next;
    res_scr   <= res_scr_next;
    res_cell  <= res_cell_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{PAD_W{1'b0}}, res_cell, res_scr,
                  tcw_pkg::CROW_W'(row), tcw_pkg::CCOL_W'(col)};
    end
  end

endmodule

// ===== rtl/text_console_writer_unit.sv =====
// Text console writer: screen of COLUMNS x ROWS cells with a cursor.
// Put, newline, backspace, unused codes and off-screen reads go from ST_IDLE to ST_DONE,
// an on-screen read through ST_READ as well, for the registered screen read port.
// A scroll moves the rows up in ST_SCR_RD and ST_SCR_WR and fills the bottom row in ST_FILL;
// a clear blanks every cell in ST_CLEAR. A put passes through the command queue and ST_DONE
// to the output register. After reset the screen is blanked in ST_INIT with s_tready low.
module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] char_code, [15:8] color, [20:16] read_row, [27:21] read_col
  input  logic [tcw_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [1:0] func
  input  logic [tcw_pkg::FUNC_W-1:0]         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [12] scrolled, [28:13] cell_data
  output logic [tcw_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  tcw_pkg::queue_head_t head;
  logic                 pop;
  logic                 accept_en;

  // Accept and classify transactions
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept_en (accept_en),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .pop       (pop),
    .head      (head)
  );

  // Execute commands against the screen
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .accept_en (accept_en),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== bench/console_checker.sv =====
`timescale 1ns / 100ps
// Checker for the text console writer: watches both stream channels, keeps its own
// copy of the screen and cursor, and compares each result against the prediction.
// Depends on tcw_pkg for field widths, function codes and character codes.
module console_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [tcw_pkg::FUNC_W-1:0]      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                              fail_count,
  output int                              pending_count,
  output int                              read_count,
  output int                              clear_count,
  output int                              scroll_count
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [CCOL_W-1:0] col;
    logic [CROW_W-1:0] row;
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
  } console_status_t;

  // Shadow screen, cursor and the statuses still owed by the block
  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  console_status_t   expected_status_q [$];
  int                errors;
  int                reads;
  int                clears;
  int                scrolls;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    read_count    = 0;
    clear_count   = 0;
    scroll_count  = 0;
    errors        = 0;
    reads         = 0;
    clears        = 0;
    scrolls       = 0;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = {BLANK_ATTR, SPACE_CHAR};
    cur_col = 0;
    cur_row = 0;
  endfunction

  // Update the shadow console with one transaction and return the status it produces
  function automatic console_status_t apply_console_item(
    input logic [FUNC_W-1:0] func,
    input logic [CHAR_W-1:0] ch,
    input logic [ATTR_W-1:0] attr,
    input logic [RROW_W-1:0] rrow,
    input logic [RCOL_W-1:0] rcol
  );
    console_status_t st;
    logic            did_scroll;
    st         = '0;
    did_scroll = 1'b0;
    case (func)
      FUNC_PUT: begin
        if (ch == NEWLINE_CHAR) begin
          cur_col = 0;
          cur_row++;
        end else if (ch == BACKSPACE_CHAR) begin
          // backspace at column zero leaves everything alone
          if (cur_col > 0) begin
            cur_col--;
            screen[cur_row * COLUMNS + cur_col] = {attr, SPACE_CHAR};
          end
        end else begin
          screen[cur_row * COLUMNS + cur_col] = {attr, ch};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // scroll up one row, new bottom row blank in the item's attribute
        if (cur_row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen[i] = {attr, SPACE_CHAR};
          cur_row    = ROWS - 1;
          did_scroll = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        blank_screen();
      end
      FUNC_READ: begin
        // a read off the screen returns zero
        if (rrow < ROWS && rcol < COLUMNS) st.cell_data = screen[rrow * COLUMNS + rcol];
      end
      default: begin
      end
    endcase
    st.col      = CCOL_W'(cur_col);
    st.row      = CROW_W'(cur_row);
    st.scrolled = did_scroll;
    return st;
  endfunction

  // Predict on every input transaction, compare on every output transaction
  always @(posedge clk) begin
    console_status_t exp_st;
    console_status_t got;
    if (rst) begin
      blank_screen();
      expected_status_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        exp_st = apply_console_item(s_tuser, s_tdata[7:0], s_tdata[15:8],
                                    s_tdata[20:16], s_tdata[27:21]);
        expected_status_q.push_back(exp_st);
        if (s_tuser == FUNC_READ) reads++;
        if (s_tuser == FUNC_CLEAR) clears++;
        if (exp_st.scrolled) scrolls++;
      end
      if (m_tvalid && m_tready) begin
        got.col       = m_tdata[6:0];
        got.row       = m_tdata[11:7];
        got.scrolled  = m_tdata[12];
        got.cell_data = m_tdata[28:13];
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual 0x%08h", $time, m_tdata);
          errors++;
        end else begin
          exp_st = expected_status_q.pop_front();
          if (got.col !== exp_st.col) begin
            $display("%0t: cursor_col expected %0d actual %0d", $time, exp_st.col, got.col);
            errors++;
          end
          if (got.row !== exp_st.row) begin
            $display("%0t: cursor_row expected %0d actual %0d", $time, exp_st.row, got.row);
            errors++;
          end
          if (got.scrolled !== exp_st.scrolled) begin
            $display("%0t: scrolled expected %0d actual %0d", $time, exp_st.scrolled,
                     got.scrolled);
            errors++;
          end
          if (got.cell_data !== exp_st.cell_data) begin
            $display("%0t: cell_data expected 0x%04h actual 0x%04h", $time,
                     exp_st.cell_data, got.cell_data);
            errors++;
          end
        end
      end
    end
    fail_count    <= errors;
    pending_count <= expected_status_q.size();
    read_count    <= reads;
    clear_count   <= clears;
    scroll_count  <= scrolls;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the text console writer bench: clock, reset, stimulus and verdict.
// Instantiates text_console_writer_unit and console_checker; uses tcw_pkg codes.
module tb_top;
  import tcw_pkg::*;

  localparam int COLUMNS = COLUMNS_DEF;
  localparam int ROWS    = ROWS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [FUNC_W-1:0]      s_tuser  = '0;
  logic                   m_tready = 1'b0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fail_count;
  int pending_count;
  int read_count;
  int clear_count;
  int scroll_count;
  int items_sent = 0;
  bit idle_on    = 1'b1;
  int stall_left = 0;

  text_console_writer_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  console_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .read_count    (read_count),
    .clear_count   (clear_count),
    .scroll_count  (scroll_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Guard against a hung run
  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random while idling is enabled
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Drive one transaction, hold until accepted, then maybe idle
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch,
                           input logic [ATTR_W-1:0] color, input logic [RROW_W-1:0] rrow,
                           input logic [RCOL_W-1:0] rcol);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0000, rcol, rrow, color, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] color);
    send_item(FUNC_PUT, ch, color, RROW_W'($urandom), RCOL_W'($urandom));
  endtask

  task automatic read_cell(input logic [RROW_W-1:0] rrow, input logic [RCOL_W-1:0] rcol);
    send_item(FUNC_READ, CHAR_W'($urandom), ATTR_W'($urandom), rrow, rcol);
  endtask

  initial begin
    int                r;
    int                n;
    logic [ATTR_W-1:0] color;
    logic [CHAR_W-1:0] ch;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: blank after reset, extreme bytes, backspace cases, odd reads
    read_cell('0, '0);
    put_char(8'h00, 8'h00);
    put_char(8'hFF, 8'hFF);
    put_char(8'h41, 8'h1E);
    read_cell('0, '0);
    read_cell('0, RCOL_W'(1));
    read_cell('0, RCOL_W'(2));
    put_char(BACKSPACE_CHAR, 8'h4F);
    read_cell('0, RCOL_W'(2));
    repeat (3) put_char(BACKSPACE_CHAR, 8'hA5);
    read_cell('0, '0);
    put_char(NEWLINE_CHAR, 8'h07);
    put_char(SPACE_CHAR, 8'h70);
    send_item(FUNC_UNUSED, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
    read_cell(5'd31, 7'd127);
    read_cell(RROW_W'(ROWS), '0);
    read_cell('0, RCOL_W'(COLUMNS));
    read_cell(RROW_W'(ROWS - 1), RCOL_W'(COLUMNS - 1));
    send_item(FUNC_CLEAR, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
    read_cell('0, '0);

    // Random phrases of console traffic
    while (items_sent < 825) begin
      // alternate stretches with and without idling
      idle_on = ((items_sent / 150) % 2) == 0;
      r = $urandom_range(0, 99);
      color = ATTR_W'($urandom);
      if (r < 38) begin
        // short text run, sometimes ended by a newline
        n = $urandom_range(1, 16);
        repeat (n) begin
          ch = CHAR_W'($urandom);
          if (ch == NEWLINE_CHAR || ch == BACKSPACE_CHAR) ch = SPACE_CHAR;
          if ($urandom_range(0, 3) == 0) color = ATTR_W'($urandom);
          put_char(ch, color);
        end
        if ($urandom_range(0, 1) == 0) put_char(NEWLINE_CHAR, color);
      end else if (r < 40) begin
        // long line that can wrap past the last column
        n = $urandom_range(40, 85);
        repeat (n) put_char(CHAR_W'($urandom_range(8'h21, 8'hFF)), color);
      end else if (r < 53) begin
        // newline burst, occasionally long enough to scroll several times
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 26) : $urandom_range(1, 6);
        repeat (n) put_char(NEWLINE_CHAR, ATTR_W'($urandom));
      end else if (r < 63) begin
        // backspace run, sometimes retyped
        n = $urandom_range(1, 8);
        repeat (n) put_char(BACKSPACE_CHAR, ATTR_W'($urandom));
        if ($urandom_range(0, 1) == 0) put_char(CHAR_W'($urandom), color);
      end else if (r < 88) begin
        // reads, biased toward the bottom rows where scrolls land
        n = $urandom_range(1, 5);
        repeat (n) begin
          r = $urandom_range(0, 9);
          if (r < 5) begin
            read_cell(RROW_W'($urandom_range(ROWS - 3, ROWS - 1)),
                      RCOL_W'($urandom_range(0, COLUMNS - 1)));
          end else if (r < 8) begin
            read_cell(RROW_W'($urandom_range(0, ROWS - 1)),
                      RCOL_W'($urandom_range(0, COLUMNS - 1)));
          end else begin
            read_cell(RROW_W'($urandom), RCOL_W'($urandom));
          end
        end
      end else if (r < 89) begin
        send_item(FUNC_CLEAR, CHAR_W'($urandom), color, RROW_W'($urandom), RCOL_W'($urandom));
      end else begin
        // noise: unused code or fully random transactions
        n = $urandom_range(1, 2);
        repeat (n) begin
          send_item(($urandom_range(0, 1) == 0) ? FUNC_UNUSED : FUNC_W'($urandom),
                    CHAR_W'($urandom), ATTR_W'($urandom), RROW_W'($urandom),
                    RCOL_W'($urandom));
        end
      end
    end

    // Drain remaining results
    idle_on = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions: %0d cell reads, %0d clears, %0d scrolls checked.",
             items_sent, read_count, clear_count, scroll_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
